// File: rtl/sbt_pkg.sv
// Package for the source byte tokenizer: transaction types, scan mode codes,
// token and literal kind codes, and byte class functions.
// No dependencies.
package sbt_pkg;

	// Default widths for the position counters.
	localparam int OffsetBitsDefault = 32;
	localparam int LineBitsDefault = 24;

	// Depth of the result queue, in entries of up to two tokens.
	localparam int QueueDepth = 2;

	// Scan mode codes.
	localparam logic [3:0] MODE_IDLE      = 4'd0;
	localparam logic [3:0] MODE_DIRECTIVE = 4'd1;
	localparam logic [3:0] MODE_TAG       = 4'd2;
	localparam logic [3:0] MODE_STRING    = 4'd3;
	localparam logic [3:0] MODE_ZERO      = 4'd4;
	localparam logic [3:0] MODE_NUMBER    = 4'd5;
	localparam logic [3:0] MODE_SYNRUN    = 4'd6;
	localparam logic [3:0] MODE_OPRUN     = 4'd7;
	localparam logic [3:0] MODE_SLASH     = 4'd8;
	localparam logic [3:0] MODE_COMMENT   = 4'd9;
	localparam logic [3:0] MODE_IDENT     = 4'd10;

	// Token kinds.
	localparam logic [2:0] TOK_DIRECTIVE = 3'd0;
	localparam logic [2:0] TOK_TAG       = 3'd1;
	localparam logic [2:0] TOK_SYNTAX    = 3'd2;
	localparam logic [2:0] TOK_LITERAL   = 3'd3;
	localparam logic [2:0] TOK_OPERATOR  = 3'd4;
	localparam logic [2:0] TOK_IDENT     = 3'd5;

	// Literal kinds.
	localparam logic [2:0] LIT_NONE    = 3'd0;
	localparam logic [2:0] LIT_STRING  = 3'd1;
	localparam logic [2:0] LIT_HEX     = 3'd2;
	localparam logic [2:0] LIT_BINARY  = 3'd3;
	localparam logic [2:0] LIT_DECIMAL = 3'd4;
	localparam logic [2:0] LIT_FRACT   = 3'd5;

	// Characters with a special meaning.
	localparam logic [7:0] CH_NL     = 8'h0A;
	localparam logic [7:0] CH_TAB    = 8'h09;
	localparam logic [7:0] CH_SPACE  = 8'h20;
	localparam logic [7:0] CH_QUOTE  = 8'h22;
	localparam logic [7:0] CH_BSLASH = 8'h5C;
	localparam logic [7:0] CH_SLASH  = 8'h2F;
	localparam logic [7:0] CH_AT     = 8'h40;
	localparam logic [7:0] CH_HASH   = 8'h23;
	localparam logic [7:0] CH_ZERO   = 8'h30;
	localparam logic [7:0] CH_X      = 8'h78;
	localparam logic [7:0] CH_B      = 8'h62;
	localparam logic [7:0] CH_DOT    = 8'h2E;
	localparam logic [7:0] CH_UNDER  = 8'h5F;
	localparam logic [7:0] CH_COLON  = 8'h3A;

	// One source byte transaction.
	typedef struct packed {
		logic [7:0] in_byte;
		logic       end_of_file;
	} byte_item_t;

	// One token descriptor transaction.
	typedef struct packed {
		logic [2:0]  token_kind;
		logic [2:0]  literal_kind;
		logic [23:0] line_number;
		logic [15:0] column;
		logic [31:0] start_offset;
		logic [15:0] token_length;
		logic        well_formed;
		logic [15:0] line_length;
		logic        last_of_run;
	} token_t;

	// Operator characters: all printable punctuation except underscore.
	function automatic logic is_op(input logic [7:0] b);
		logic r;
		begin
			case (b) inside
				[8'h21:8'h2F], [8'h3A:8'h40], [8'h5B:8'h5E], 8'h60, [8'h7B:8'h7E]: r = 1'b1;
				default: r = 1'b0;
			endcase
			return r;
		end
	endfunction

	function automatic logic is_ident(input logic [7:0] b);
		return !(b == CH_SPACE || b == CH_TAB || b == CH_NL || is_op(b));
	endfunction

	function automatic logic is_dec(input logic [7:0] b);
		return b == CH_UNDER || (b >= 8'h30 && b <= 8'h39);
	endfunction

	function automatic logic is_hex(input logic [7:0] b);
		return is_dec(b) || (b >= 8'h61 && b <= 8'h7A) || (b >= 8'h41 && b <= 8'h5A);
	endfunction

	function automatic logic is_bin(input logic [7:0] b);
		return b == CH_UNDER || b == 8'h30 || b == 8'h31;
	endfunction

endpackage

// File: rtl/source_byte_tokenizer.sv
// Source byte tokenizer top level: scan state, token emission and result queue.
// Depends on sbt_pkg.
//
// Usage: source bytes enter on the byte channel (byte_valid, byte_stall,
// byte_data), one transaction per byte, with end_of_file set on the last
// byte of a file. Token descriptors leave on the token channel
// (token_valid, token_stall, token_data). A byte may give zero, one or two
// tokens; last_of_run marks the final token of one byte.
// The tokens of a byte are written into the result queue when the byte is
// accepted. Throughput: one byte per cycle while the receiver keeps up; a
// byte that gives two tokens holds the token channel until both are taken.
// The rate is set by the two-entry result queue, which accepts one byte's
// tokens per cycle. When the receiver stalls, the queue fills and
// byte_stall rises once it has no free entry; no token is lost.
// Reset clears the scan state (line, column and offset counters to zero,
// scan mode idle) and empties the queue. After a byte with end_of_file the
// open token is flushed and the scan state returns to its reset value.
module source_byte_tokenizer #(
	parameter int OFFSET_BITS = sbt_pkg::OffsetBitsDefault,
	parameter int LINE_BITS = sbt_pkg::LineBitsDefault
) (
	input  logic                clk,
	input  logic                arst_n,
	input  logic                byte_valid,
	output logic                byte_stall,
	input  sbt_pkg::byte_item_t byte_data,
	output logic                token_valid,
	input  logic                token_stall,
	output sbt_pkg::token_t     token_data
);
	import sbt_pkg::*;

	localparam int PtrBits = $clog2(QueueDepth);
	localparam int CntBits = $clog2(QueueDepth + 1);

	typedef struct packed {
		logic   two;
		token_t r0;
		token_t r1;
	} entry_t;

	// Scan state.
	logic [3:0]             mode_q;
	logic [LINE_BITS-1:0]   line_q;
	logic [15:0]            col_q;
	logic [OFFSET_BITS-1:0] off_q;
	logic [OFFSET_BITS-1:0] tb_q;
	logic [15:0]            tc_q;
	logic [OFFSET_BITS-1:0] lb_q;
	logic [2:0]             nk_q;
	logic                   pb_q;

	// Saturating length from a base to an end offset.
	function automatic logic [15:0] sat_len(input logic [OFFSET_BITS-1:0] e,
		input logic [OFFSET_BITS-1:0] s);
		logic [OFFSET_BITS-1:0] d;
		begin
			d = e - s;
			if (d > OFFSET_BITS'(32'hFFFF)) return 16'hFFFF;
			return d[15:0];
		end
	endfunction

	function automatic token_t mk(input logic [2:0] kind, input logic [2:0] lit,
		input logic [15:0] len, input logic wf, input logic [15:0] ll,
		input logic [LINE_BITS-1:0] ln, input logic [15:0] tc,
		input logic [OFFSET_BITS-1:0] tb);
		token_t t;
		begin
			t.token_kind = kind;
			t.literal_kind = lit;
			t.line_number = 24'(ln);
			t.column = tc;
			t.start_offset = 32'(tb);
			t.token_length = len;
			t.well_formed = wf;
			t.line_length = ll;
			t.last_of_run = 1'b0;
			return t;
		end
	endfunction

	// Kind of the token that a mode flushes; valid is low for no token.
	function automatic logic [6:0] flush_info(input logic [3:0] m, input logic [2:0] nk);
		logic [6:0] r;
		begin
			unique case (m)
				MODE_DIRECTIVE: r = {1'b1, TOK_DIRECTIVE, LIT_NONE};
				MODE_TAG:       r = {1'b1, TOK_TAG, LIT_NONE};
				MODE_IDENT:     r = {1'b1, TOK_IDENT, LIT_NONE};
				MODE_STRING:    r = {1'b1, TOK_LITERAL, LIT_STRING};
				MODE_ZERO:      r = {1'b1, TOK_LITERAL, LIT_DECIMAL};
				MODE_NUMBER:    r = {1'b1, TOK_LITERAL, nk};
				MODE_SYNRUN:    r = {1'b1, TOK_SYNTAX, LIT_NONE};
				MODE_OPRUN,
				MODE_SLASH:     r = {1'b1, TOK_OPERATOR, LIT_NONE};
				default:        r = 7'd0;
			endcase
			return r;
		end
	endfunction

	// Queue of result entries.
	entry_t             queue_q [QueueDepth];
	logic [PtrBits-1:0] wr_q;
	logic [PtrBits-1:0] rd_q;
	logic [CntBits-1:0] cnt_q;
	logic               sub_q;

	logic byte_acc;
	logic token_acc;
	logic pop;
	logic push;

	assign byte_stall = (cnt_q == CntBits'(QueueDepth));
	assign byte_acc = byte_valid && !byte_stall;
	assign token_valid = (cnt_q != '0);
	assign token_acc = token_valid && !token_stall;
	assign pop = token_acc && (!queue_q[rd_q].two || sub_q);
	assign token_data = sub_q ? queue_q[rd_q].r1 : queue_q[rd_q].r0;

	// Next scan state and the tokens this byte gives.
	logic [3:0]             mode_d;
	logic [LINE_BITS-1:0]   line_d;
	logic [15:0]            col_d;
	logic [OFFSET_BITS-1:0] off_d;
	logic [OFFSET_BITS-1:0] tb_d;
	logic [15:0]            tc_d;
	logic [OFFSET_BITS-1:0] lb_d;
	logic [2:0]             nk_d;
	logic                   pb_d;
	token_t                 res [2];
	logic [1:0]             n;

	always_comb begin
		logic [7:0]             b;
		logic                   taken;
		logic                   nl;
		logic [OFFSET_BITS-1:0] p;
		logic [OFFSET_BITS-1:0] p1;
		logic [6:0]             fi;
		logic                   do_flush;

		b = byte_data.in_byte;
		p = off_q;
		p1 = off_q + OFFSET_BITS'(1);
		mode_d = mode_q;
		line_d = line_q;
		col_d = col_q;
		tb_d = tb_q;
		tc_d = tc_q;
		lb_d = lb_q;
		nk_d = nk_q;
		pb_d = pb_q;
		taken = 1'b0;
		nl = 1'b0;
		do_flush = 1'b0;
		fi = 7'd0;
		n = 2'd0;
		res[0] = '0;
		res[1] = '0;

		// Continue or end the open token.
		case (mode_q)
			MODE_DIRECTIVE, MODE_TAG, MODE_IDENT: begin
				if (is_ident(b)) taken = 1'b1;
				else do_flush = 1'b1;
			end
			MODE_STRING: begin
				if (b == CH_NL) begin
					do_flush = 1'b1;
				end else if (b == CH_QUOTE && !pb_q) begin
					taken = 1'b1;
					res[0] = mk(TOK_LITERAL, LIT_STRING, sat_len(p1, tb_q), 1'b1, 16'd0,
						line_q, tc_q, tb_q);
					n = 2'd1;
					mode_d = MODE_IDLE;
				end else begin
					taken = 1'b1;
					pb_d = (b == CH_BSLASH);
				end
			end
			MODE_ZERO: begin
				if (b == CH_X || b == CH_B) begin
					taken = 1'b1;
					mode_d = MODE_NUMBER;
					nk_d = (b == CH_X) ? LIT_HEX : LIT_BINARY;
				end else begin
					mode_d = MODE_NUMBER;
					if (b == CH_DOT) begin
						taken = 1'b1;
						nk_d = LIT_FRACT;
					end else if (is_dec(b)) begin
						taken = 1'b1;
						nk_d = LIT_DECIMAL;
					end else begin
						nk_d = LIT_DECIMAL;
						do_flush = 1'b1;
					end
				end
			end
			MODE_NUMBER: begin
				if (nk_q == LIT_DECIMAL && b == CH_DOT) begin
					taken = 1'b1;
					nk_d = LIT_FRACT;
				end else if ((nk_q == LIT_DECIMAL || nk_q == LIT_FRACT) && is_dec(b))
					taken = 1'b1;
				else if (nk_q == LIT_HEX && is_hex(b)) taken = 1'b1;
				else if (nk_q == LIT_BINARY && is_bin(b)) taken = 1'b1;
				else do_flush = 1'b1;
			end
			MODE_SLASH: begin
				if (b == CH_SLASH) begin
					taken = 1'b1;
					mode_d = MODE_COMMENT;
				end else if (is_op(b)) begin
					taken = 1'b1;
					mode_d = MODE_OPRUN;
				end else begin
					do_flush = 1'b1;
				end
			end
			MODE_SYNRUN, MODE_OPRUN: begin
				if (is_op(b)) taken = 1'b1;
				else do_flush = 1'b1;
			end
			MODE_COMMENT: begin
				if (b != CH_NL) taken = 1'b1;
				else mode_d = MODE_IDLE;
			end
			default: mode_d = MODE_IDLE;
		endcase

		if (do_flush) begin
			fi = flush_info(mode_q, nk_d);
			res[0] = mk(fi[5:3], fi[2:0], sat_len(p, tb_q), fi[5:3] != TOK_LITERAL ||
				fi[2:0] != LIT_STRING, 16'd0, line_q, tc_q, tb_q);
			n = 2'd1;
			mode_d = MODE_IDLE;
		end

		// Start a new token with this byte.
		if (!taken) begin
			tb_d = p;
			tc_d = col_q;
			if (b == CH_AT) mode_d = MODE_DIRECTIVE;
			else if (b == CH_HASH) mode_d = MODE_TAG;
			else if (b == CH_SPACE || b == CH_TAB) mode_d = MODE_IDLE;
			else if (b == CH_NL) begin
				res[n[0]] = mk(TOK_SYNTAX, LIT_NONE, 16'd1, 1'b1, sat_len(p, lb_q),
					line_q, col_q, p);
				n = n + 2'd1;
				nl = 1'b1;
				mode_d = MODE_IDLE;
			end else if (b == CH_QUOTE) begin
				mode_d = MODE_STRING;
				pb_d = 1'b0;
			end else if (b == CH_ZERO) mode_d = MODE_ZERO;
			else if (b >= 8'h31 && b <= 8'h39) begin
				mode_d = MODE_NUMBER;
				nk_d = LIT_DECIMAL;
			end else if (b == 8'h2C || b == 8'h28 || b == 8'h29 || b == 8'h7B ||
				b == 8'h7D) begin
				res[n[0]] = mk(TOK_SYNTAX, LIT_NONE, 16'd1, 1'b1, 16'd0, line_q, col_q, p);
				n = n + 2'd1;
				mode_d = MODE_IDLE;
			end else if (b == CH_COLON) mode_d = MODE_SYNRUN;
			else if (b == CH_SLASH) mode_d = MODE_SLASH;
			else if (is_op(b)) mode_d = MODE_OPRUN;
			else mode_d = MODE_IDENT;
		end

		// Position counters.
		off_d = p1;
		if (nl) begin
			line_d = line_q + LINE_BITS'(1);
			lb_d = p1;
			col_d = 16'd0;
		end else if (col_q != 16'hFFFF) begin
			col_d = col_q + 16'd1;
		end

		// End of file flushes the open token and returns to reset state.
		if (byte_data.end_of_file) begin
			fi = flush_info(mode_d, nk_d);
			if (fi[6]) begin
				res[n[0]] = mk(fi[5:3], fi[2:0], sat_len(p1, tb_d), fi[5:3] != TOK_LITERAL ||
					fi[2:0] != LIT_STRING, 16'd0, line_d, tc_d, tb_d);
				n = n + 2'd1;
			end
			mode_d = MODE_IDLE;
			line_d = '0;
			col_d = 16'd0;
			off_d = '0;
			tb_d = '0;
			tc_d = 16'd0;
			lb_d = '0;
			nk_d = 3'd0;
			pb_d = 1'b0;
		end

		if (n == 2'd2) res[1].last_of_run = 1'b1;
		else res[0].last_of_run = 1'b1;
	end

	assign push = byte_acc && (n != 2'd0);

	// Scan state registers.
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			mode_q <= MODE_IDLE;
			line_q <= '0;
			col_q <= 16'd0;
			off_q <= '0;
			tb_q <= '0;
			tc_q <= 16'd0;
			lb_q <= '0;
			nk_q <= 3'd0;
			pb_q <= 1'b0;
		end else if (byte_acc) begin
			mode_q <= mode_d;
			line_q <= line_d;
			col_q <= col_d;
			off_q <= off_d;
			tb_q <= tb_d;
			tc_q <= tc_d;
			lb_q <= lb_d;
			nk_q <= nk_d;
			pb_q <= pb_d;
		end
	end

	// Result queue storage.
	always_ff @(posedge clk) begin
		if (push) begin
			queue_q[wr_q].two <= (n == 2'd2);
			queue_q[wr_q].r0 <= res[0];
			queue_q[wr_q].r1 <= res[1];
		end
	end

	// Result queue pointers and the token select within an entry.
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			wr_q <= '0;
			rd_q <= '0;
			cnt_q <= '0;
			sub_q <= 1'b0;
		end else begin
			if (push) wr_q <= (wr_q == PtrBits'(QueueDepth - 1)) ? '0 : wr_q + PtrBits'(1);
			if (pop) rd_q <= (rd_q == PtrBits'(QueueDepth - 1)) ? '0 : rd_q + PtrBits'(1);
			if (token_acc) sub_q <= !pop;
			if (push && !pop) cnt_q <= cnt_q + CntBits'(1);
			else if (pop && !push) cnt_q <= cnt_q - CntBits'(1);
		end
	end

endmodule
